@@ hdl/crclf_pkg.sv @@
// ----------------------------------------------------------------------------
// crclf_pkg
// Shared types, constants and the byte-wide CRC-16 update for the length
// framer.
// ----------------------------------------------------------------------------
`default_nettype none

package crclf_pkg;

   localparam int unsigned      MAX_RESULTS      = 5;
   localparam int unsigned      CNT_W            = $clog2(MAX_RESULTS + 1);
   localparam logic [15:0]      CRC_POLY         = 16'hA001;
   localparam logic [7:0]       MAX_PAYLOAD_RST  = 8'd60;

   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
   localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_FIVE  = CNT_W'(5);

   // Results caused by one accepted item; bytes[0] goes out first.
   typedef struct packed {
      logic [CNT_W-1:0]             count;
      logic                         done;
      logic                         err;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
   } plan_type;

   // Reflected CRC-16, one byte per call.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/crclf_ctrl.sv @@
// ----------------------------------------------------------------------------
// crclf_ctrl
// Packet state, CRC accumulator and length limit register; works out the
// results that each accepted byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module crclf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [7:0]         csr_wdata,
   input  wire logic               item_accept,
   input  wire logic [7:0]         data_byte,
   input  wire logic [7:0]         payload_len,
   input  wire logic               frame_mode,
   output crclf_pkg::plan_type     plan
);

   logic        in_packet_ff, in_packet_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_acc_ff, crc_acc_in;
   logic [7:0]  max_payload_ff;
   logic [15:0] crc_next;
   logic [7:0]  len_inv;

   assign crc_next = crclf_pkg::crc_byte(in_packet_ff ? crc_acc_ff : 16'h0000, data_byte);
   assign len_inv  = ~payload_len;

   always_comb begin
      in_packet_in  = in_packet_ff;
      bytes_left_in = bytes_left_ff;
      crc_acc_in    = crc_acc_ff;
      plan          = '0;
      if (in_packet_ff) begin
         crc_acc_in     = crc_next;
         plan.bytes[0]  = data_byte;
         plan.bytes[1]  = crc_next[15:8];
         plan.bytes[2]  = crc_next[7:0];
         bytes_left_in  = bytes_left_ff - 8'd1;
         if (bytes_left_ff == 8'd1) begin
            plan.count   = crclf_pkg::CNT_THREE;
            plan.done    = 1'b1;
            in_packet_in = 1'b0;
         end else begin
            plan.count = crclf_pkg::CNT_ONE;
         end
      end else if (payload_len > max_payload_ff) begin
         plan.count = crclf_pkg::CNT_ONE;
         plan.done  = 1'b1;
         plan.err   = 1'b1;
      end else if (!frame_mode) begin
         plan.count    = crclf_pkg::CNT_ONE;
         plan.done     = 1'b1;
         plan.bytes[0] = data_byte;
      end else begin
         plan.bytes[0] = payload_len;
         plan.bytes[1] = len_inv;
         if (payload_len == 8'd0) begin
            crc_acc_in = 16'h0000;
            plan.count = crclf_pkg::CNT_FOUR;
            plan.done  = 1'b1;
         end else if (payload_len == 8'd1) begin
            crc_acc_in    = crc_next;
            plan.bytes[2] = data_byte;
            plan.bytes[3] = crc_next[15:8];
            plan.bytes[4] = crc_next[7:0];
            plan.count    = crclf_pkg::CNT_FIVE;
            plan.done     = 1'b1;
         end else begin
            crc_acc_in    = crc_next;
            plan.bytes[2] = data_byte;
            plan.count    = crclf_pkg::CNT_THREE;
            in_packet_in  = 1'b1;
            bytes_left_in = payload_len - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff   <= 1'b0;
         bytes_left_ff  <= 8'd0;
         crc_acc_ff     <= 16'h0000;
         max_payload_ff <= crclf_pkg::MAX_PAYLOAD_RST;
      end else begin
         if (csr_we) begin
            max_payload_ff <= csr_wdata;
         end
         if (item_accept) begin
            in_packet_ff  <= in_packet_in;
            bytes_left_ff <= bytes_left_in;
            crc_acc_ff    <= crc_acc_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/crclf_emit.sv @@
// ----------------------------------------------------------------------------
// crclf_emit
// Result register: holds the bytes of one item and shifts them out one per
// transfer; takes the next item while its last byte is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module crclf_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire crclf_pkg::plan_type plan,
   output logic                     load_ok,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   logic [crclf_pkg::CNT_W-1:0]                     cnt_ff;
   logic                                            done_ff;
   logic                                            err_ff;
   logic [crclf_pkg::MAX_RESULTS-1:0][7:0]          slot_ff;
   logic [crclf_pkg::MAX_RESULTS-1:0][7:0]          slot_in;
   logic                                            take;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = slot_ff[0];
   assign rsp_tlast  = done_ff && (cnt_ff == crclf_pkg::CNT_ONE);
   assign rsp_tuser  = err_ff;
   assign take       = rsp_tvalid && rsp_tready;
   assign load_ok    = (cnt_ff == '0) || ((cnt_ff == crclf_pkg::CNT_ONE) && rsp_tready);

   always_comb begin
      slot_in = {8'h00, slot_ff[crclf_pkg::MAX_RESULTS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= plan.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - crclf_pkg::CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= plan.bytes;
         done_ff <= plan.done;
         err_ff  <= plan.err;
      end else if (take) begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/crc16_length_framer.sv @@
// First result byte is valid in the cycle after the input transfer.
// Throughput: one result byte per cycle unless rsp_tready stalls; an input
// byte causes one to five result bytes (header and CRC footer), so input is
// taken at that pace, set by the single result shift register's drain rate.
// Reset: synchronous, active high; clears packet state, CRC and pending
// results, and sets max_payload to 60.
// ----------------------------------------------------------------------------
// crc16_length_framer
// Frames payload bytes with a length header and CRC-16 footer, or passes
// bytes raw.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_length_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_wdata,   // max_payload
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] payload_len
   input  wire logic        req_tuser,   // frame_mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // frame_end
   output logic             rsp_tuser    // length_error
);

   crclf_pkg::plan_type plan;
   logic                item_accept;

   assign csr_ready   = 1'b1;
   assign item_accept = req_tvalid && req_tready;

   crclf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_valid),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .data_byte   (req_tdata[7:0]),
      .payload_len (req_tdata[15:8]),
      .frame_mode  (req_tuser),
      .plan        (plan)
   );

   crclf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (item_accept),
      .plan       (plan),
      .load_ok    (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ hdl/crclf_checker.sv @@
// ----------------------------------------------------------------------------
// crclf_checker
// Port-level checks for the length framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crclf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted item gave no result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result transfer stalled");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("malformed length error result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind crc16_length_framer crclf_checker u_crclf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
